// ----- hdl/cesel_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cesel_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPOSIT_THR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_DEP_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_ENERGY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_ENABLE   = 3'd4;

  localparam logic [2:0] TRACK_COUNT_RESET = 3'd2;

  localparam logic [2:0] VERDICT_FEW_HITS = 3'd0;
  localparam logic [2:0] VERDICT_MISSING  = 3'd1;
  localparam logic [2:0] VERDICT_SHARED   = 3'd2;
  localparam logic [2:0] VERDICT_ENERGY   = 3'd3;
  localparam logic [2:0] VERDICT_ACCEPTED = 3'd4;

  localparam logic MODE_HIT   = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] event_id;
    logic [3:0]  track_id;
    logic [4:0]  scatter_index;
    logic [9:0]  scint_id;
    logic [15:0] deposit;
    logic [15:0] emission_energy;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] closed_event_id;
    logic [4:0]  min_scatters;
    logic [7:0]  hit_total;
    logic [31:0] count_events;
    logic [31:0] count_enough_hits;
    logic [31:0] count_all_tracks;
    logic [31:0] count_distinct_scint;
    logic [31:0] count_detected;
  } out_item_t;

  // outcome of the per-stage checks on a closing event
  typedef struct packed {
    logic [2:0] verdict;
    logic       enough_hits;
    logic       all_tracks;
    logic       distinct_scint;
    logic       energy_ok;
    logic [4:0] min_scatters;
  } judge_t;

endpackage

`default_nettype wire

// ----- hdl/cesel_track_bank.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cesel_track_bank
  import cesel_pkg::*;
#(
  parameter int MAX_TRACKS = 4,
  parameter int TCW        = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clear,
  input  wire logic                          record,
  input  wire logic [TCW-1:0]                tc,
  input  wire logic [3:0]                    track_id,
  input  wire logic [4:0]                    scatter_index,
  input  wire logic [9:0]                    scint_id,
  input  wire logic [15:0]                   deposit,
  input  wire logic                          is_prompt,
  output logic [MAX_TRACKS-1:0]              has_hit,
  output logic [MAX_TRACKS-1:0][9:0]         first_scint,
  output logic [MAX_TRACKS-1:0][15:0]        first_deposit,
  output logic [MAX_TRACKS-1:0]              first_prompt,
  output logic [MAX_TRACKS-1:0][4:0]         max_scatter
);

  logic [MAX_TRACKS-1:0]       has_hit_r, has_hit_nxt;
  logic [MAX_TRACKS-1:0][4:0]  max_scatter_r, max_scatter_nxt;
  logic [MAX_TRACKS-1:0][9:0]  first_scint_r;
  logic [MAX_TRACKS-1:0][15:0] first_deposit_r;
  logic [MAX_TRACKS-1:0]       first_prompt_r;
  logic [MAX_TRACKS-1:0]       wr_track;
  logic [MAX_TRACKS-1:0]       wr_first;

  always_comb begin
    for (int i = 0; i < MAX_TRACKS; i++) begin
      // a closing item (hit or flush) clears the bank, so the next event starts from a clean slate
      has_hit_nxt[i]     = clear ? 1'b0 : has_hit_r[i];
      max_scatter_nxt[i] = clear ? 5'd0 : max_scatter_r[i];
      wr_track[i] = record && (track_id == 4'(i + 1)) && (TCW'(i) < tc);
      wr_first[i] = wr_track[i] && !has_hit_nxt[i];
      if (wr_track[i]) begin
        has_hit_nxt[i] = 1'b1;
        if (scatter_index > max_scatter_nxt[i]) begin
          max_scatter_nxt[i] = scatter_index;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_hit_r     <= '0;
      max_scatter_r <= '0;
    end else begin
      has_hit_r     <= has_hit_nxt;
      max_scatter_r <= max_scatter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TRACKS; i++) begin
      if (wr_first[i]) begin
        first_scint_r[i]   <= scint_id;
        first_deposit_r[i] <= deposit;
        first_prompt_r[i]  <= is_prompt;
      end
    end
  end

  assign has_hit       = has_hit_r;
  assign max_scatter   = max_scatter_r;
  assign first_scint   = first_scint_r;
  assign first_deposit = first_deposit_r;
  assign first_prompt  = first_prompt_r;

endmodule

`default_nettype wire

// ----- hdl/cesel_judge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cesel_judge
  import cesel_pkg::*;
#(
  parameter int MAX_TRACKS = 4,
  parameter int TCW        = 3
) (
  input  wire logic [TCW-1:0]                tc,
  input  wire logic [7:0]                    hits_seen,
  input  wire logic [MAX_TRACKS-1:0]         has_hit,
  input  wire logic [MAX_TRACKS-1:0][9:0]    first_scint,
  input  wire logic [MAX_TRACKS-1:0][15:0]   first_deposit,
  input  wire logic [MAX_TRACKS-1:0]         first_prompt,
  input  wire logic [MAX_TRACKS-1:0][4:0]    max_scatter,
  input  wire logic [15:0]                   deposit_threshold,
  input  wire logic [15:0]                   prompt_deposit_threshold,
  input  wire logic                          prompt_enable,
  output judge_t                             judge
);

  logic        all_tracks;
  logic        distinct;
  logic        energy_ok;
  logic        enough;
  logic [4:0]  ms;
  logic [15:0] thr;

  always_comb begin
    enough     = hits_seen >= 8'(tc);
    all_tracks = 1'b1;
    distinct   = 1'b1;
    energy_ok  = 1'b1;
    thr        = deposit_threshold;
    ms         = max_scatter[0];
    for (int i = 0; i < MAX_TRACKS; i++) begin
      if (TCW'(i) < tc) begin
        if (!has_hit[i]) begin
          all_tracks = 1'b0;
        end
        thr = (prompt_enable && first_prompt[i]) ? prompt_deposit_threshold
                                                 : deposit_threshold;
        if (!(first_deposit[i] > thr)) begin
          energy_ok = 1'b0;
        end
        if (max_scatter[i] < ms) begin
          ms = max_scatter[i];
        end
      end
      for (int j = i + 1; j < MAX_TRACKS; j++) begin
        if ((TCW'(j) < tc) && (first_scint[i] == first_scint[j])) begin
          distinct = 1'b0;
        end
      end
    end
  end

  always_comb begin
    judge.enough_hits    = enough;
    judge.all_tracks     = all_tracks;
    judge.distinct_scint = distinct;
    judge.energy_ok      = energy_ok;
    judge.min_scatters   = ms;
    priority if (!enough) begin
      judge.verdict = VERDICT_FEW_HITS;
    end else if (!all_tracks) begin
      judge.verdict = VERDICT_MISSING;
    end else if (!distinct) begin
      judge.verdict = VERDICT_SHARED;
    end else if (!energy_ok) begin
      judge.verdict = VERDICT_ENERGY;
    end else begin
      judge.verdict = VERDICT_ACCEPTED;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/coincidence_event_selector.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Event selector for detector hits grouped by event id.
// Input channel (in_valid/in_ready/in_item): one hit or flush item per cycle.
// A hit with a new event id closes the open event and opens the next one;
// a flush closes the open event (a flush with no open event does nothing).
// Output channel (out_valid/out_ready/out_item): one verdict per closed
// event, with the event's hit total, least per-track maximum scatter index
// and the five stage counters after that event.
// An accepted item is held in the input register; when it closes an
// event, its result is written to the output register and out_valid rises.
// Throughput is one item per cycle unless a closing item waits for the
// output register, set by the single input register to output register pass.
// When the receiver stalls, the input register keeps taking hits that close
// nothing; an item that closes an event waits until the output register is
// free, and in_ready drops only then.
// The user writes configuration (cfg_we/cfg_index/cfg_wdata) only while idle;
// the block does not enforce it. Reset (rst_n low, synchronous) clears the
// event, the counters, both registers' valid flags; loads defaults (two tracks).

module coincidence_event_selector
  import cesel_pkg::*;
#(
  parameter int MAX_TRACKS = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int TCW = $clog2(MAX_TRACKS + 1);

  // configuration registers
  logic [2:0]  track_count_r;
  logic [15:0] deposit_threshold_r;
  logic [15:0] prompt_deposit_threshold_r;
  logic [15:0] prompt_energy_r;
  logic        prompt_enable_r;

  // input register
  in_item_t    ir_item_r;
  logic        ir_valid_r;

  // event state
  logic [31:0] open_event_id_r, open_event_id_nxt;
  logic        event_open_r, event_open_nxt;
  logic [7:0]  hits_seen_r, hits_seen_nxt;
  logic [4:0][31:0] counters_r, counters_nxt;

  out_item_t   out_item_r;
  logic        out_valid_r;

  logic [3:0]     tc_wide;
  logic [TCW-1:0] tc;
  logic           closes;
  logic           out_free;
  logic           consume;
  logic           is_hit;
  logic           bank_clear;
  logic           bank_record;
  logic           is_prompt;
  logic [7:0]     hits_base;

  logic [MAX_TRACKS-1:0]       has_hit;
  logic [MAX_TRACKS-1:0][9:0]  first_scint;
  logic [MAX_TRACKS-1:0][15:0] first_deposit;
  logic [MAX_TRACKS-1:0]       first_prompt;
  logic [MAX_TRACKS-1:0][4:0]  max_scatter;
  judge_t                      judge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_count_r              <= TRACK_COUNT_RESET;
      deposit_threshold_r        <= '0;
      prompt_deposit_threshold_r <= '0;
      prompt_energy_r            <= '0;
      prompt_enable_r            <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRACK_COUNT:    track_count_r              <= cfg_wdata[2:0];
        CFG_DEPOSIT_THR:    deposit_threshold_r        <= cfg_wdata;
        CFG_PROMPT_DEP_THR: prompt_deposit_threshold_r <= cfg_wdata;
        CFG_PROMPT_ENERGY:  prompt_energy_r            <= cfg_wdata;
        CFG_PROMPT_ENABLE:  prompt_enable_r            <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective track count: 0 acts as 1, clipped at MAX_TRACKS
  always_comb begin
    tc_wide = {1'b0, track_count_r};
    if (tc_wide == 4'd0) begin
      tc_wide = 4'd1;
    end else if (tc_wide > 4'(MAX_TRACKS)) begin
      tc_wide = 4'(MAX_TRACKS);
    end
    tc = tc_wide[TCW-1:0];
  end

  assign is_hit   = (ir_item_r.mode == MODE_HIT);
  assign closes   = ir_valid_r && event_open_r &&
                    (!is_hit || (ir_item_r.event_id != open_event_id_r));
  assign out_free = !out_valid_r || out_ready;
  assign consume  = ir_valid_r && (!closes || out_free);
  assign in_ready = !ir_valid_r || consume;

  assign bank_clear  = consume && closes;
  assign bank_record = consume && is_hit;
  assign is_prompt   = (ir_item_r.emission_energy == prompt_energy_r);

  cesel_track_bank #(
    .MAX_TRACKS (MAX_TRACKS),
    .TCW        (TCW)
  ) u_bank (
    .clk           (clk),
    .rst_n         (rst_n),
    .clear         (bank_clear),
    .record        (bank_record),
    .tc            (tc),
    .track_id      (ir_item_r.track_id),
    .scatter_index (ir_item_r.scatter_index),
    .scint_id      (ir_item_r.scint_id),
    .deposit       (ir_item_r.deposit),
    .is_prompt     (is_prompt),
    .has_hit       (has_hit),
    .first_scint   (first_scint),
    .first_deposit (first_deposit),
    .first_prompt  (first_prompt),
    .max_scatter   (max_scatter)
  );

  cesel_judge #(
    .MAX_TRACKS (MAX_TRACKS),
    .TCW        (TCW)
  ) u_judge (
    .tc                       (tc),
    .hits_seen                (hits_seen_r),
    .has_hit                  (has_hit),
    .first_scint              (first_scint),
    .first_deposit            (first_deposit),
    .first_prompt             (first_prompt),
    .max_scatter              (max_scatter),
    .deposit_threshold        (deposit_threshold_r),
    .prompt_deposit_threshold (prompt_deposit_threshold_r),
    .prompt_enable            (prompt_enable_r),
    .judge                    (judge)
  );

  always_comb begin
    open_event_id_nxt = open_event_id_r;
    event_open_nxt    = event_open_r;
    hits_seen_nxt     = hits_seen_r;
    counters_nxt      = counters_r;
    hits_base         = closes ? 8'd0 : hits_seen_r;
    if (consume) begin
      if (closes) begin
        counters_nxt[0] = counters_r[0] + 32'd1;
        counters_nxt[1] = counters_r[1] + 32'(judge.enough_hits);
        counters_nxt[2] = counters_r[2] + 32'(judge.enough_hits && judge.all_tracks);
        counters_nxt[3] = counters_r[3] + 32'(judge.enough_hits && judge.all_tracks &&
                                              judge.distinct_scint);
        counters_nxt[4] = counters_r[4] + 32'(judge.verdict == VERDICT_ACCEPTED);
      end
      if (is_hit) begin
        if (closes || !event_open_r) begin
          open_event_id_nxt = ir_item_r.event_id;
        end
        event_open_nxt = 1'b1;
        hits_seen_nxt  = (hits_base == 8'hFF) ? hits_base : hits_base + 8'd1;
      end else if (closes) begin
        event_open_nxt = 1'b0;
        hits_seen_nxt  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r      <= 1'b0;
      open_event_id_r <= '0;
      event_open_r    <= 1'b0;
      hits_seen_r     <= '0;
      counters_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        ir_valid_r <= in_valid;
      end
      open_event_id_r <= open_event_id_nxt;
      event_open_r    <= event_open_nxt;
      hits_seen_r     <= hits_seen_nxt;
      counters_r      <= counters_nxt;
      if (bank_clear) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ir_item_r <= in_item;
    end
    if (bank_clear) begin
      out_item_r.verdict              <= judge.verdict;
      out_item_r.closed_event_id      <= open_event_id_r;
      out_item_r.min_scatters         <= judge.min_scatters;
      out_item_r.hit_total            <= hits_seen_r;
      out_item_r.count_events         <= counters_nxt[0];
      out_item_r.count_enough_hits    <= counters_nxt[1];
      out_item_r.count_all_tracks     <= counters_nxt[2];
      out_item_r.count_distinct_scint <= counters_nxt[3];
      out_item_r.count_detected       <= counters_nxt[4];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_close_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && closes) |=> out_valid_r)
    else $error("closed event produced no result");

  a_idle_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
    !event_open_r |-> (hits_seen_r == 8'd0))
    else $error("hit count nonzero with no open event");

  a_hit_opens_event: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && is_hit) |=> (event_open_r && hits_seen_r != 8'd0))
    else $error("accepted hit left no open event");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.verdict <= VERDICT_ACCEPTED))
    else $error("verdict code out of range");

endmodule

`default_nettype wire
